FILE: hw/rtl/wpm_pkg.sv
// wpm_pkg: shared types and constants of the wildcard pattern matcher
// no dependencies; imported by every module of the block
`default_nettype none

package wpm_pkg;

    // pattern geometry
    localparam int PATTERN_MAX = 63;
    localparam int CELL_COUNT  = PATTERN_MAX + 1;
    localparam int POS_W       = $clog2(CELL_COUNT);
    localparam int SYM_W       = 8;
    localparam int ACTION_W    = 2;

    // wildcard characters
    localparam logic [SYM_W-1:0] SYM_ANY = 8'h3F;   // '?'
    localparam logic [SYM_W-1:0] SYM_RUN = 8'h2A;   // '*'

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD = 2'd0,
        ACT_TEXT = 2'd1,
        ACT_END  = 2'd2
    } action_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic step;     // a text character is consumed
        logic clear;    // end of text, drop all active positions
    } wpm_cell_ctrl_t;

    // link from one cell to its right-hand neighbour
    typedef struct packed {
        logic carry;    // star closure reaches the neighbour
        logic adv;      // text character advances into the neighbour
    } wpm_link_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wildcard_pattern_matcher_core.sv
// wildcard_pattern_matcher_core: top level of the wildcard pattern matcher
// depends on wpm_pkg, wpm_cell, wpm_out_skid
`default_nettype none

//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------
//  input     | in_valid / in_ready    | action, position, symbol
//  output    | out_valid / out_ready  | matched
//  config    | cfg_valid / cfg_ready  | pattern_length
//
//  one input word is taken every cycle that in_ready is high; a load or
//  text word is absorbed in the cycle it is taken, an end word shows its
//  result in the next cycle; the cycle time is set by the star closure
//  rippling along the row of cells; results wait in a two-word buffer;
//  in_ready drops only while that buffer holds two unread words
//  reset leaves position zero armed and the length at zero; the pattern
//  characters are unknown until loaded
//  cfg_ready is always high

module wildcard_pattern_matcher_core
    import wpm_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [ACTION_W-1:0] action,
    input  wire logic [POS_W-1:0]    position,
    input  wire logic [SYM_W-1:0]    symbol,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     matched,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [POS_W-1:0]    pattern_length
);

    logic [POS_W-1:0]    pattern_length_reg;
    logic [POS_W-1:0]    len_used;
    logic                fresh_reg;
    logic                fresh_next;
    logic                in_fire;
    logic                load_fire;
    logic                text_fire;
    logic                end_fire;
    logic                buf_full;
    wpm_cell_ctrl_t      ctrl;
    wpm_link_t           link_in  [CELL_COUNT];
    wpm_link_t           link_out [CELL_COUNT];
    logic [CELL_COUNT-1:0] closed_vec;
    logic [CELL_COUNT-1:0] in_use_vec;
    logic [CELL_COUNT-1:0] wr_en_vec;

    // ---------------------------------------------------------------
    // handshakes and word decode
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign in_ready  = !buf_full;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        load_fire = 1'b0;
        text_fire = 1'b0;
        end_fire  = 1'b0;
        case (action_t'(action))
            ACT_LOAD: load_fire = in_fire;
            ACT_TEXT: text_fire = in_fire;
            ACT_END:  end_fire  = in_fire;
            default:  load_fire = 1'b0;     // unused code, word is dropped
        endcase
    end

    assign ctrl.step  = text_fire;
    assign ctrl.clear = end_fire;

    // length register; anything above PATTERN_MAX is clamped to PATTERN_MAX
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pattern_length_reg <= pattern_length;
        end
    end

    assign len_used = (pattern_length_reg > POS_W'(PATTERN_MAX)) ?
                      POS_W'(PATTERN_MAX) : pattern_length_reg;

    // ---------------------------------------------------------------
    // start token: position zero is armed after reset and after each end
    // word; it enters the row as closure into the first cell, so the cell
    // registers themselves all reset to zero
    // ---------------------------------------------------------------
    always_comb
    begin
        fresh_next = fresh_reg;
        if (end_fire)
        begin
            fresh_next = 1'b1;
        end
        else if (text_fire)
        begin
            fresh_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
        end
        else
        begin
            fresh_reg <= fresh_next;
        end
    end

    // ---------------------------------------------------------------
    // row of cells, one per pattern position plus the final position
    // ---------------------------------------------------------------
    assign link_in[0].carry = fresh_reg;
    assign link_in[0].adv   = 1'b0;

    for (genvar p = 0; p < CELL_COUNT; p++)
    begin : g_cell
        // a cell takes part only below the length in use
        assign in_use_vec[p] = ({1'b0, POS_W'(p)} < {1'b0, len_used});
        // the final position holds no character and is never written
        assign wr_en_vec[p]  = load_fire && (position == POS_W'(p))
                               && (position < POS_W'(PATTERN_MAX));

        if (p > 0)
        begin : g_chain
            assign link_in[p] = link_out[p-1];
        end

        wpm_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_en    (wr_en_vec[p]),
            .in_use   (in_use_vec[p]),
            .symbol   (symbol),
            .link_in  (link_in[p]),
            .link_out (link_out[p]),
            .closed   (closed_vec[p])
        );
    end

    // ---------------------------------------------------------------
    // result buffer: end word reports the closed bit at the length in use
    // ---------------------------------------------------------------
    wpm_out_skid u_out_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (end_fire),
        .push_data (closed_vec[len_used]),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched)
    );

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_end_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        end_fire |=> out_valid)
        else $error("end word produced no result");

    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        end_fire |=> (fresh_reg && (closed_vec[0] || !in_use_vec[0]
                      || closed_vec[0] == fresh_reg)))
        else $error("start position not rearmed after end word");

    a_text_consumes_start: assert property (@(posedge clk) disable iff (!rst_n)
        text_fire |=> !fresh_reg)
        else $error("start token kept after text character");

    a_row_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !link_out[CELL_COUNT-1].carry && !link_out[CELL_COUNT-1].adv)
        else $error("activity passed beyond the final position");

endmodule

`default_nettype wire

FILE: hw/rtl/wpm_cell.sv
// wpm_cell: one pattern position, holding its character and its active bit
// depends on wpm_pkg
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire wpm_cell_ctrl_t ctrl,
    input  wire logic           wr_en,
    input  wire logic           in_use,
    input  wire logic [SYM_W-1:0] symbol,
    input  wire wpm_link_t      link_in,
    output wpm_link_t           link_out,
    output logic                closed
);

    logic [SYM_W-1:0] char_reg;
    logic             act_reg;
    logic             act_next;
    logic             is_star;
    logic             hit;
    logic             keep;

    // pattern character, no reset: only read once loaded
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_reg <= symbol;
        end
    end

    always_comb
    begin
        is_star        = (char_reg == SYM_RUN);
        hit            = (char_reg == SYM_ANY) || (char_reg == symbol);
        closed         = act_reg || link_in.carry;
        keep           = in_use && is_star && closed;
        link_out.carry = keep;
        link_out.adv   = in_use && !is_star && closed && hit;
    end

    always_comb
    begin
        act_next = act_reg;
        if (ctrl.clear)
        begin
            act_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            act_next = keep || link_in.adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wpm_out_skid.sv
// wpm_out_skid: two-word result buffer between the cell row and the output port
// depends on wpm_pkg (imported for house consistency)
`default_nettype none

module wpm_out_skid
    import wpm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire logic push_data,
    output logic      full,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      matched
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       slot0_reg;
    logic       slot0_next;
    logic       slot1_reg;
    logic       slot1_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign matched   = slot0_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case ({push, pop})
            2'b10:
            begin
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd0)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot1_next = push_data;
                end
            end
            2'b01:
            begin
                count_next = count_reg - 2'd1;
                slot0_next = slot1_reg;
            end
            2'b11:
            begin
                // one word in, one out: only reachable with a single word held
                slot0_next = push_data;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into full buffer");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push && count_reg == 2'd1) |=> !out_valid)
        else $error("buffer not empty after last word taken");

endmodule

`default_nettype wire
